// ===== rtl/shifting_array_store_unit_assert.svh =====
// Assertion macros used by the checker file of the shifting array store.
`ifndef SHIFTING_ARRAY_STORE_UNIT_ASSERT_SVH
`define SHIFTING_ARRAY_STORE_UNIT_ASSERT_SVH

// Check a property on the rising clock edge, disabled while reset is low.
`define SAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SAS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/sas_pkg.sv =====
// Types and constants of the shifting array store.
`default_nettype none

package sas_pkg;

  // Storage geometry
  localparam int Depth = 64;
  localparam int WordW = 32;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  // Configuration register map
  localparam logic RegCapIdx = 1'b0;
  localparam logic [CntW-1:0] CapReset = CntW'(Depth);

  // Request codes
  typedef enum logic [2:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_READ   = 3'd4,
    MODE_WRITE  = 3'd5
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Request beat
  typedef struct packed {
    mode_e       mode;
    logic [5:0]  index;
    logic [31:0] data_in;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [31:0] data_out;
    logic [6:0]  length;
    logic        is_empty;
    logic        is_full;
    status_e     status;
  } out_item_t;

  // Command from the controller to the datapath
  typedef struct packed {
    logic  exec;
    mode_e mode;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/shifting_array_store_unit.sv =====
// Top level of the shifting array store.
`default_nettype none

// Ordered array of up to 64 words with push, pop, insert, remove, read and
// write requests; every request gives exactly one result beat carrying the
// read word, the new length, empty and full flags and a status code. The
// result is registered at the edge that accepts the request, and a new
// request is accepted in the same cycle as the previous result is taken, so
// the unit sustains one request per cycle while the receiver takes every
// result. The register-cell array makes this possible: each cell can load a
// neighbor's word, so that an insert or remove shifts the whole array at
// once. The array is cleared by reset directly, with no clearing pass. The
// capacity register sits at byte address 0 of the APB port; values 0 and
// above 64 act as 1 and 64.
module shifting_array_store_unit import sas_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_item_t  out_data_o,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [2:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  cmd_t        cmd;
  logic        cfg_we;
  logic [31:0] cfg_rdata;

  // Decode the register write on the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == RegCapIdx);
  assign prdata = (paddr[2] == RegCapIdx) ? cfg_rdata : '0;

  sas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_data_i.mode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  sas_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .index_i     (in_data_i.index[IdxW-1:0]),
    .data_in_i   (in_data_i.data_in),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata),
    .cfg_rdata_o (cfg_rdata),
    .result_o    (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/sas_ctrl.sv =====
// Controller of the shifting array store: request and result handshakes.
`default_nettype none

module sas_ctrl import sas_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  input  mode_e in_mode_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  wire   out_ready_i,
  output cmd_t  cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StHold = 1'b1;

  logic state_q, state_d;
  logic exec;

  // Take a new beat when no result waits or the waiting one leaves now
  assign in_ready_o  = (state_q == StIdle) || out_ready_i;
  assign exec        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StHold);

  assign cmd_o.exec = exec;
  assign cmd_o.mode = in_mode_i;

  // Advance between idle and holding a result
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (exec) state_d = StHold;
      end
      StHold: begin
        if (exec) state_d = StHold;
        else if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sas_datapath.sv =====
// Datapath of the shifting array store: cell array, length, capacity, result.
`default_nettype none

module sas_datapath import sas_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  cmd_t            cmd_i,
  input  wire [IdxW-1:0]  index_i,
  input  wire [31:0]      data_in_i,
  input  wire             cfg_we_i,
  input  wire [31:0]      cfg_wdata_i,
  output logic [31:0]     cfg_rdata_o,
  output out_item_t       result_o
);

  logic [WordW-1:0] cell_q [Depth];
  logic [WordW-1:0] cell_d [Depth];
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  lim_q;
  logic [CntW-1:0]  cap;
  logic [CntW-1:0]  idx;
  logic [WordW-1:0] din;
  logic [WordW-1:0] rd;
  status_e          st;
  logic do_push, do_pop, do_ins, do_rem, do_rd, do_wr;
  out_item_t        res_q;

  assign idx = CntW'(index_i);
  assign din = data_in_i[WordW-1:0];

  // Saturate the capacity register to 1..Depth
  always_comb begin
    if (lim_q == '0) cap = CntW'(1);
    else if (lim_q > CntW'(Depth)) cap = CntW'(Depth);
    else cap = lim_q;
  end

  // Decode the request and check it against length and capacity
  always_comb begin
    do_push = 1'b0;
    do_pop  = 1'b0;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    do_rd   = 1'b0;
    do_wr   = 1'b0;
    st      = ST_OK;
    case (cmd_i.mode)
      MODE_PUSH: begin
        if (count_q >= cap) st = ST_FULL;
        else do_push = 1'b1;
      end
      MODE_POP: begin
        if (count_q == '0) st = ST_EMPTY;
        else do_pop = 1'b1;
      end
      MODE_INSERT: begin
        if (idx > count_q) st = ST_RANGE;
        else if (count_q >= cap) st = ST_FULL;
        else do_ins = 1'b1;
      end
      MODE_REMOVE: begin
        if (count_q == '0) st = ST_EMPTY;
        else if (idx >= count_q) st = ST_RANGE;
        else do_rem = 1'b1;
      end
      MODE_READ: begin
        if (count_q == '0) st = ST_EMPTY;
        else if (idx >= count_q) st = ST_RANGE;
        else do_rd = 1'b1;
      end
      MODE_WRITE: begin
        if (idx >= cap) st = ST_RANGE;
        else do_wr = 1'b1;
      end
      default: st = ST_RANGE;
    endcase
  end

  // New length after the request
  always_comb begin
    count_d = count_q;
    if (do_push || do_ins) count_d = count_q + CntW'(1);
    else if (do_pop || do_rem) count_d = count_q - CntW'(1);
    else if (do_wr && (idx >= count_q)) count_d = idx + CntW'(1);
  end

  // Each cell takes its own word, a neighbor's word, or the new word
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [WordW-1:0] lower;
    logic [WordW-1:0] upper;
    if (g > 0) begin : g_lo
      assign lower = cell_q[g-1];
    end else begin : g_lo0
      assign lower = '0;
    end
    if (g < Depth - 1) begin : g_up
      assign upper = cell_q[g+1];
    end else begin : g_up0
      assign upper = '0;
    end

    always_comb begin
      cell_d[g] = cell_q[g];
      if (do_push && (count_q == CntW'(g))) begin
        cell_d[g] = din;
      end
      if (do_ins) begin
        if (idx == CntW'(g)) cell_d[g] = din;
        else if ((CntW'(g) > idx) && (CntW'(g) <= count_q)) cell_d[g] = lower;
      end
      if (do_rem && (CntW'(g) >= idx) && ((CntW'(g) + CntW'(1)) < count_q)) begin
        cell_d[g] = upper;
      end
      if (do_wr && (idx == CntW'(g))) begin
        cell_d[g] = din;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cell_q[g] <= '0;
      end else if (cmd_i.exec) begin
        cell_q[g] <= cell_d[g];
      end
    end
  end

  // Read port
  assign rd = do_rd ? cell_q[index_i] : '0;

  // Hold length and capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lim_q   <= CapReset;
    end else begin
      if (cmd_i.exec) count_q <= count_d;
      if (cfg_we_i) lim_q <= cfg_wdata_i[CntW-1:0];
    end
  end

  assign cfg_rdata_o = 32'(lim_q);

  // Capture the result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q.data_out <= 32'(rd);
      res_q.length   <= 7'(count_d);
      res_q.is_empty <= (count_d == '0);
      res_q.is_full  <= (count_d >= cap);
      res_q.status   <= st;
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/sas_checker.sv =====
// Port-level checker of the shifting array store and its binding.
`default_nettype none
`include "shifting_array_store_unit_assert.svh"

module sas_checker import sas_pkg::*; (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input out_item_t  out_data_o
);

  // No result beat while reset is held
  `SAS_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result valid during reset")

  // A stalled result beat holds
  `SAS_ASSERT(a_result_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // Every accepted request yields a result on the next cycle
  `SAS_ASSERT(a_result_follows, in_valid_i && in_ready_o |=> out_valid_o, "request gave no result")

  // Empty flag and length agree, and the length stays within the array
  `SAS_ASSERT(a_len_flags, out_valid_o |-> (out_data_o.is_empty == (out_data_o.length == 7'd0)) && (out_data_o.length <= 7'(Depth)), "length and flags disagree")

  // A refused request reads nothing
  `SAS_ASSERT(a_data_zero, out_valid_o && (out_data_o.status != ST_OK) |-> (out_data_o.data_out == 32'd0), "data on refused request")

endmodule

bind shifting_array_store_unit sas_checker u_sas_checker (.*);

`default_nettype wire

// ===== tb/sas_result_checker.sv =====
// Scoreboard for the shifting array store: watches both channels and the APB port.
`timescale 1ns / 100ps

module sas_result_checker import sas_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  in_item_t    in_data_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  out_item_t   out_data_i,
  input  wire         psel_i,
  input  wire         penable_i,
  input  wire         pwrite_i,
  input  wire         pready_i,
  input  wire [2:0]   paddr_i,
  input  wire [31:0]  pwdata_i,
  output int          pending_o,
  output int          checked_o,
  output int          mismatch_o
);

  localparam logic [2:0] CapRegAddr = 3'(4 * RegCapIdx);
  localparam int ReportLimit = 10;

  // Shadow copy of the array, its fill level and the capacity register
  logic [WordW-1:0] words [Depth];
  int               fill_level;
  logic [6:0]       cap_reg;
  out_item_t        expected_q [$];

  // Apply one request to the shadow array and return the result it yields
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t res;
    int        cap;
    int        idx;
    int        i;
    cap = (cap_reg == 0) ? 1 : (cap_reg > Depth) ? Depth : int'(cap_reg);
    idx = int'(req.index);
    res = '0;
    res.status = ST_OK;
    case (req.mode)
      MODE_PUSH: begin
        if (fill_level >= cap) begin
          res.status = ST_FULL;
        end else begin
          words[fill_level] = req.data_in;
          fill_level++;
        end
      end
      MODE_POP: begin
        if (fill_level == 0) res.status = ST_EMPTY;
        else fill_level--;
      end
      MODE_INSERT: begin
        // index is checked before fullness; index equal to length appends
        if (idx > fill_level) begin
          res.status = ST_RANGE;
        end else if (fill_level >= cap) begin
          res.status = ST_FULL;
        end else begin
          for (i = fill_level; i > idx; i--) words[i] = words[i-1];
          words[idx] = req.data_in;
          fill_level++;
        end
      end
      MODE_REMOVE: begin
        if (fill_level == 0) begin
          res.status = ST_EMPTY;
        end else if (idx >= fill_level) begin
          res.status = ST_RANGE;
        end else begin
          for (i = idx; i + 1 < fill_level; i++) words[i] = words[i+1];
          fill_level--;
        end
      end
      MODE_READ: begin
        if (fill_level == 0) res.status = ST_EMPTY;
        else if (idx >= fill_level) res.status = ST_RANGE;
        else res.data_out = words[idx];
      end
      MODE_WRITE: begin
        // a write past the end extends the length, gap entries keep old words
        if (idx >= cap) begin
          res.status = ST_RANGE;
        end else begin
          words[idx] = req.data_in;
          if (idx >= fill_level) fill_level = idx + 1;
        end
      end
      default: res.status = ST_RANGE;
    endcase
    res.length   = 7'(fill_level);
    res.is_empty = (fill_level == 0);
    res.is_full  = (fill_level >= cap);
    return res;
  endfunction

  // Track config writes, queue predictions, compare result beats in order
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int        k;
    logic      bad;
    if (!rst_ni) begin
      for (k = 0; k < Depth; k++) words[k] = '0;
      fill_level = 0;
      cap_reg    = CapReset;
      expected_q.delete();
      pending_o  = 0;
      checked_o  = 0;
      mismatch_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == CapRegAddr) begin
        cap_reg = pwdata_i[6:0];
      end
      if (in_valid_i && in_ready_i) expected_q = {expected_q, apply_request(in_data_i)};
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatch_o++;
          if (mismatch_o <= ReportLimit) begin
            $display("%0t: result beat with nothing expected: data %h len %0d st %0d",
                     $realtime, out_data_i.data_out, out_data_i.length, out_data_i.status);
          end
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          bad = (out_data_i.data_out !== want.data_out) ||
                (out_data_i.length   !== want.length)   ||
                (out_data_i.is_empty !== want.is_empty) ||
                (out_data_i.is_full  !== want.is_full)  ||
                (out_data_i.status   !== want.status);
          if (bad) begin
            mismatch_o++;
            if (mismatch_o <= ReportLimit) begin
              $display("%0t: mismatch exp data %h len %0d emp %b full %b st %0d",
                       $realtime, want.data_out, want.length, want.is_empty,
                       want.is_full, want.status);
              $display("%0t:          got data %h len %0d emp %b full %b st %0d",
                       $realtime, out_data_i.data_out, out_data_i.length,
                       out_data_i.is_empty, out_data_i.is_full, out_data_i.status);
            end
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top-level testbench of the shifting array store: stimulus, APB setup and verdict.
`timescale 1ns / 100ps

module tb;
  import sas_pkg::*;

  localparam logic [2:0] CapRegAddr = 3'(4 * RegCapIdx);
  localparam logic [2:0] ModeSpareA = 3'd6;
  localparam logic [2:0] ModeSpareB = 3'd7;
  localparam int HoldCycles   = 200;
  localparam int PhaseCount   = 8;
  localparam int PhaseItems   = 165;
  localparam int MaxSendGap   = 40;

  logic        clk_i       = 1'b0;
  logic        rst_ni;
  logic        in_valid_i  = 1'b0;
  in_item_t    in_data_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;

  wire         in_ready_o;
  wire         out_valid_o;
  out_item_t   out_data_o;
  wire [31:0]  prdata;
  wire         pready;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_seq       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int sent_count     = 0;
  int pending;
  int checked;
  int mismatches;
  int cap_plan [PhaseCount] = '{64, 5, 127, 1, 0, 17, 64, 3};

  shifting_array_store_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  sas_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pending_o   (pending),
    .checked_o   (checked),
    .mismatch_o  (mismatches)
  );

  always #4 clk_i = ~clk_i;

  // Drive the result ready: random stalls, plus a long hold when requested
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= HoldCycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request beat after an optional gap and hold it until taken
  task automatic send_req(input mode_e m, input logic [5:0] idx, input logic [31:0] word);
    int gap;
    gap = 0;
    while (gap < MaxSendGap && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_data_i.mode    <= m;
    in_data_i.index   <= idx;
    in_data_i.data_in <= word;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  // Drop valid and wait until every outstanding result has been taken
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // APB write of the capacity register: setup cycle, then access cycle
  task automatic write_capacity(input logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CapRegAddr;
    pwdata  <= {25'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pick a request kind, biased toward growing or shrinking the array
  function automatic mode_e pick_mode(input logic grow);
    int r;
    r = $urandom_range(99);
    if (grow) begin
      if (r < 30) return MODE_PUSH;
      if (r < 50) return MODE_INSERT;
      if (r < 58) return MODE_POP;
      if (r < 66) return MODE_REMOVE;
    end else begin
      if (r < 12) return MODE_PUSH;
      if (r < 20) return MODE_INSERT;
      if (r < 45) return MODE_POP;
      if (r < 66) return MODE_REMOVE;
    end
    if (r < 82) return MODE_READ;
    if (r < 97) return MODE_WRITE;
    if (r < 99) return mode_e'(ModeSpareA);
    return mode_e'(ModeSpareB);
  endfunction

  // Mostly random words, with all-zero and all-one words mixed in
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Run limit
  initial begin
    #5_000_000;
    $display("shifting_array_store_unit test failed");
    $finish;
  end

  // Stimulus
  initial begin
    int ph;
    int n;
    int eff;
    int idx_hi;
    logic [5:0] idx;

    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty array: every take refused, spare modes, insert past the end
    send_req(MODE_POP,    6'd0,  32'h0);
    send_req(MODE_REMOVE, 6'd0,  32'h0);
    send_req(MODE_READ,   6'd0,  32'h0);
    send_req(mode_e'(ModeSpareA), 6'd63, 32'hFFFF_FFFF);
    send_req(mode_e'(ModeSpareB), 6'd21, 32'h1234_5678);
    send_req(MODE_INSERT, 6'd1,  32'h1111_1111);
    // Build a few entries: insert at front, push, append and mid insert
    send_req(MODE_INSERT, 6'd0,  32'hFFFF_FFFF);
    send_req(MODE_PUSH,   6'd0,  32'h0);
    send_req(MODE_PUSH,   6'd42, 32'hA5A5_A5A5);
    send_req(MODE_INSERT, 6'd3,  32'h5A5A_5A5A);
    send_req(MODE_INSERT, 6'd1,  32'h1234_5678);
    send_req(MODE_READ,   6'd1,  32'h0);
    send_req(MODE_REMOVE, 6'd5,  32'h0);
    send_req(MODE_REMOVE, 6'd0,  32'h0);
    send_req(MODE_READ,   6'd63, 32'h0);
    // Write at the top index fills the array; then full refusals
    send_req(MODE_WRITE,  6'd63, 32'hDEAD_BEEF);
    send_req(MODE_PUSH,   6'd1,  32'hCAFE_F00D);
    send_req(MODE_INSERT, 6'd2,  32'hCAFE_F00D);
    send_req(MODE_READ,   6'd63, 32'h0);
    send_req(MODE_READ,   6'd10, 32'h0);
    send_req(MODE_POP,    6'd0,  32'h0);
    // Capacity lowered below the length keeps the entries
    settle();
    write_capacity(7'd2);
    send_req(MODE_PUSH,   6'd0,  32'h0BAD_0BAD);
    send_req(MODE_WRITE,  6'd2,  32'h0BAD_0BAD);
    send_req(MODE_WRITE,  6'd1,  32'h7777_7777);
    send_req(MODE_READ,   6'd1,  32'h0);
    // Capacity zero acts as one, above the depth acts as the depth
    settle();
    write_capacity(7'd0);
    send_req(MODE_WRITE,  6'd1,  32'h0);
    send_req(MODE_WRITE,  6'd0,  32'h8000_0001);
    settle();
    write_capacity(7'd127);
    send_req(MODE_PUSH,   6'd0,  32'h0F0F_0F0F);

    // Random phases over capacity settings and idle mixes
    for (ph = 0; ph < PhaseCount; ph++) begin
      settle();
      write_capacity(7'(cap_plan[ph]));
      case (ph / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      eff    = (cap_plan[ph] == 0) ? 1 : (cap_plan[ph] > Depth) ? Depth : cap_plan[ph];
      idx_hi = (eff > 63) ? 63 : eff;
      for (n = 0; n < PhaseItems; n++) begin
        // one long receiver hold while requests keep coming
        if (ph == 0 && n == 40) hold_seq++;
        if ($urandom_range(4) == 0) idx = 6'($urandom_range(63));
        else idx = 6'($urandom_range(idx_hi));
        send_req(pick_mode((n / 20) % 2 == 0), idx, pick_word());
      end
    end

    settle();
    repeat (4) @(posedge clk_i);

    $display("Run: %0d requests sent, %0d results checked, %0d mismatching",
             sent_count, checked, mismatches);
    $display("Covered capacities 0..127, idle mixes none/sender/receiver/both, one long hold");
    if (mismatches == 0 && pending == 0) begin
      $display("shifting_array_store_unit test passed");
    end else begin
      $display("shifting_array_store_unit test failed");
    end
    $finish;
  end

endmodule
